// File: sv/lz10_pkg.sv
// shared types and codes for the lz10 stream decompressor
`default_nettype none

package lz10_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_EARLY_END = 2'd1;
  localparam logic [1:0] ERR_BAD_REF   = 2'd2;
  localparam logic [1:0] ERR_NO_ROOM   = 2'd3;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_LIT   = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;
  localparam logic [1:0] OP_ERR   = 2'd3;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_DONE = 2'd1;
  localparam logic [1:0] TAIL_EARLY = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  error_code;
    logic [24:0] consumed_size;
    logic [23:0] out_size;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  tail;
    logic [7:0]  data;
    logic [4:0]  len;
    logic [11:0] dist_m1;
    logic [1:0]  err;
    logic [23:0] base;
    logic [24:0] cons;
    logic [23:0] size;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/lz10_stream_decompressor.sv
// top level of the lz10 stream decompressor
// Compressed bytes enter on a queue-style request port: a request (item) is
// taken at a clock edge where push is high and full is low. Decoded results
// leave on a queue-style port: while empty is low the oldest result sits on
// result, and it is taken at an edge where pop is high.
// A request yields zero or more results; last_of_run marks the final one.
// The parser takes one request per cycle while full is low and hands each one
// that produces results to a 4-deep command queue, so full only rises when that
// queue fills. The executor loads a command, then issues its produced results
// one by one (one per literal, one per copied match byte, one for a finish or
// error report), holding while the result queue has no room; the single history
// write port and the one-result-per-cycle output set this.
// When pop stays low, a 4-deep result queue fills, the executor halts, then the
// command queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues and returns the parser to
// expecting header byte zero; the history needs no clearing.
`default_nettype none

module lz10_stream_decompressor #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire lz10_pkg::in_item_t  item,
  input  wire logic                pop,
  output logic                     empty,
  output lz10_pkg::out_item_t      result
);

  localparam int CQ_DEPTH = 4;

  logic           take;
  logic           cmd_push;
  lz10_pkg::cmd_t cmd;
  lz10_pkg::cmd_t cq_data;
  logic           cq_pop;
  logic           cq_empty;
  logic [$clog2(CQ_DEPTH+1)-1:0] cq_count;

  assign take = push && !full;

  lz10_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  lz10_fifo #(
    .WIDTH ($bits(lz10_pkg::cmd_t)),
    .DEPTH (CQ_DEPTH)
  ) u_cq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .pop   (cq_pop),
    .rdata (cq_data),
    .full  (full),
    .empty (cq_empty),
    .count (cq_count)
  );

  lz10_back #(
    .HIST_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_empty (cq_empty),
    .cq_data  (cq_data),
    .cq_pop   (cq_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

`default_nettype wire

// File: sv/lz10_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lz10_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/lz10_fifo.sv
// small register queue with fill count
`default_nettype none

module lz10_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/lz10_front.sv
// stream parser: header, flag and token decode into literal, copy and error commands
`default_nettype none

module lz10_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire lz10_pkg::in_item_t item,
  output logic                   cmd_push,
  output lz10_pkg::cmd_t         cmd
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_HDR2   = 3'd2;
  localparam logic [2:0] PH_HDR3   = 3'd3;
  localparam logic [2:0] PH_FLAG   = 3'd4;
  localparam logic [2:0] PH_TOKEN  = 3'd5;
  localparam logic [2:0] PH_MATCH2 = 3'd6;
  localparam logic [2:0] PH_DRAIN  = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [2:0]  flag_index, flag_index_next;
  logic [7:0]  tok, tok_next;
  logic [23:0] expected, expected_next;
  logic [23:0] produced, produced_next;
  logic [24:0] consumed, consumed_next;

  logic [7:0]  b;
  logic        token_done;
  logic [4:0]  len;
  logic [4:0]  len_c;
  logic [12:0] ref_dist;
  logic [23:0] remain;
  logic [24:0] rounded;

  assign b        = item.in_byte;
  assign len      = 5'({1'b0, tok[7:4]} + 5'd3);
  assign ref_dist = 13'({1'b0, tok[3:0], b} + 13'd1);
  assign remain   = expected - produced;
  assign len_c    = ({19'd0, len} > remain) ? remain[4:0] : len;
  // count including this request, rounded up to a multiple of four
  assign rounded  = (consumed + 25'd4) & ~25'd3;

  always_comb begin
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    flag_index_next = flag_index;
    tok_next        = tok;
    expected_next   = expected;
    produced_next   = produced;
    consumed_next   = consumed + 25'd1;
    token_done      = 1'b0;
    cmd             = '0;
    cmd.op          = lz10_pkg::OP_NONE;
    cmd.tail        = lz10_pkg::TAIL_NONE;
    cmd.base        = produced;

    unique case (phase)
      PH_HDR0: begin
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        expected_next = {16'd0, b};
        phase_next    = PH_HDR2;
      end
      PH_HDR2: begin
        expected_next = {expected[23:16], b, expected[7:0]};
        phase_next    = PH_HDR3;
      end
      PH_HDR3: begin
        expected_next = {b, expected[15:0]};
        phase_next    = PH_FLAG;
      end
      PH_FLAG: begin
        flag_bits_next  = b;
        flag_index_next = '0;
        phase_next      = PH_TOKEN;
        if (!b[7] && produced >= expected) begin
          cmd.op     = lz10_pkg::OP_ERR;
          cmd.err    = lz10_pkg::ERR_NO_ROOM;
          phase_next = PH_DRAIN;
        end
      end
      PH_TOKEN: begin
        if (flag_bits[7]) begin
          tok_next   = b;
          phase_next = PH_MATCH2;
        end else begin
          cmd.op        = lz10_pkg::OP_LIT;
          cmd.data      = b;
          produced_next = produced + 24'd1;
          token_done    = 1'b1;
        end
      end
      PH_MATCH2: begin
        if ({11'd0, ref_dist} > produced) begin
          cmd.op     = lz10_pkg::OP_ERR;
          cmd.err    = lz10_pkg::ERR_BAD_REF;
          phase_next = PH_DRAIN;
        end else begin
          cmd.op        = (len_c == '0) ? lz10_pkg::OP_NONE : lz10_pkg::OP_MATCH;
          cmd.len       = len_c;
          cmd.dist_m1   = {tok[3:0], b};
          produced_next = produced + {19'd0, len_c};
          phase_next    = PH_TOKEN;
          token_done    = 1'b1;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    if (token_done) begin
      if (produced_next == expected) begin
        cmd.tail   = lz10_pkg::TAIL_DONE;
        cmd.cons   = rounded;
        cmd.size   = expected;
        phase_next = PH_DRAIN;
      end else begin
        flag_bits_next  = {flag_bits[6:0], 1'b0};
        flag_index_next = flag_index + 3'd1;
        phase_next      = (flag_index_next == '0) ? PH_FLAG : PH_TOKEN;
      end
    end

    if (item.stream_end) begin
      if (phase_next != PH_DRAIN) begin
        cmd.tail = lz10_pkg::TAIL_EARLY;
      end
      phase_next      = PH_HDR0;
      flag_bits_next  = '0;
      flag_index_next = '0;
      tok_next        = '0;
      expected_next   = '0;
      produced_next   = '0;
      consumed_next   = '0;
    end
  end

  assign cmd_push = take && ((cmd.op != lz10_pkg::OP_NONE) || (cmd.tail != lz10_pkg::TAIL_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      flag_bits  <= '0;
      flag_index <= '0;
      tok        <= '0;
      expected   <= '0;
      produced   <= '0;
      consumed   <= '0;
    end else if (take) begin
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      flag_index <= flag_index_next;
      tok        <= tok_next;
      expected   <= expected_next;
      produced   <= produced_next;
      consumed   <= consumed_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/lz10_back.sv
// command executor: history copy, result formatting and result queue
`default_nettype none

module lz10_back #(
  parameter int HIST_DEPTH = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cq_empty,
  input  wire lz10_pkg::cmd_t  cq_data,
  output logic                 cq_pop,
  input  wire logic            pop,
  output logic                 empty,
  output lz10_pkg::out_item_t  result
);

  localparam int AW     = $clog2(HIST_DEPTH);
  localparam int ODEPTH = 4;
  localparam int CW     = $clog2(ODEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DATA = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;

  logic [1:0]          bstate;
  lz10_pkg::cmd_t      cur;
  logic [4:0]          k;

  logic                p1_valid;
  lz10_pkg::out_item_t p1_res;
  logic                p1_from_ram;
  logic                p1_bypass;
  logic [7:0]          p1_byp_byte;
  logic                p1_wen;
  logic [AW-1:0]       p1_waddr;

  logic [7:0]          ram_q;
  logic [7:0]          p1_byte;
  lz10_pkg::out_item_t ores;
  logic                ofull;
  logic [CW-1:0]       ocount;
  logic                can_issue;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [23:0]         rd_full;
  logic [23:0]         wr_full;
  logic                match_last;
  logic                no_tail;

  assign can_issue  = (ocount + CW'(p1_valid)) < CW'(ODEPTH);
  assign no_tail    = (cur.tail == lz10_pkg::TAIL_NONE);
  assign match_last = (k == cur.len - 5'd1);
  assign wr_full    = cur.base + {19'd0, k};
  assign rd_full    = wr_full - {12'd0, cur.dist_m1} - 24'd1;
  assign rd_addr    = rd_full[AW-1:0];
  assign rd_en      = (bstate == S_DATA) && can_issue && (cur.op == lz10_pkg::OP_MATCH);
  assign cq_pop     = (bstate == S_IDLE) && !cq_empty;
  assign p1_byte    = p1_from_ram ? (p1_bypass ? p1_byp_byte : ram_q) : p1_res.out_byte;

  always_comb begin
    ores          = p1_res;
    ores.out_byte = p1_byte;
  end

  lz10_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (p1_valid && p1_wen),
    .waddr (p1_waddr),
    .wdata (p1_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  lz10_fifo #(
    .WIDTH ($bits(lz10_pkg::out_item_t)),
    .DEPTH (ODEPTH)
  ) u_oq (
    .clk   (clk),
    .rst   (rst),
    .push  (p1_valid),
    .wdata (ores),
    .pop   (pop),
    .rdata (result),
    .full  (ofull),
    .empty (empty),
    .count (ocount)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate   <= S_IDLE;
      p1_valid <= 1'b0;
      k        <= '0;
    end else begin
      p1_valid <= 1'b0;
      unique case (bstate)
        S_IDLE: begin
          if (!cq_empty) begin
            k      <= '0;
            bstate <= (cq_data.op != lz10_pkg::OP_NONE) ? S_DATA : S_TAIL;
          end
        end
        S_DATA: begin
          if (can_issue) begin
            p1_valid <= 1'b1;
            if (cur.op != lz10_pkg::OP_MATCH || match_last) begin
              bstate <= no_tail ? S_IDLE : S_TAIL;
            end
            k <= k + 5'd1;
          end
        end
        S_TAIL: begin
          if (can_issue) begin
            p1_valid <= 1'b1;
            bstate   <= S_IDLE;
          end
        end
        default: begin
          bstate <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cur <= cq_data;
    end
    if (can_issue) begin
      p1_res      <= '0;
      p1_from_ram <= 1'b0;
      p1_wen      <= 1'b0;
      p1_waddr    <= wr_full[AW-1:0];
      p1_bypass   <= p1_valid && p1_wen && (p1_waddr == rd_addr);
      p1_byp_byte <= p1_byte;
      if (bstate == S_DATA) begin
        case (cur.op)
          lz10_pkg::OP_LIT: begin
            p1_res.kind        <= lz10_pkg::KIND_BYTE;
            p1_res.out_byte    <= cur.data;
            p1_res.last_of_run <= no_tail;
            p1_wen             <= 1'b1;
          end
          lz10_pkg::OP_MATCH: begin
            p1_res.kind        <= lz10_pkg::KIND_BYTE;
            p1_res.last_of_run <= no_tail && match_last;
            p1_from_ram        <= 1'b1;
            p1_wen             <= 1'b1;
          end
          default: begin
            p1_res.kind        <= lz10_pkg::KIND_ERROR;
            p1_res.error_code  <= cur.err;
            p1_res.last_of_run <= no_tail;
          end
        endcase
      end else if (cur.tail == lz10_pkg::TAIL_DONE) begin
        p1_res.kind          <= lz10_pkg::KIND_DONE;
        p1_res.consumed_size <= cur.cons;
        p1_res.out_size      <= cur.size;
        p1_res.last_of_run   <= 1'b1;
      end else begin
        p1_res.kind          <= lz10_pkg::KIND_ERROR;
        p1_res.error_code    <= lz10_pkg::ERR_EARLY_END;
        p1_res.last_of_run   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
